/* rtl/tmae_pkg.sv */
// Shared types and constants of the three-axis moving average envelope block.
`timescale 1ns / 1ps
`default_nettype none

package tmae_pkg;

  localparam int AXES = 3;

  // Saturation limits of the Q.4 mean and of the integer envelopes.
  localparam logic signed [19:0] MEAN_MIN = 20'sh80000;
  localparam logic signed [19:0] MEAN_MAX = 20'sh7FFFF;
  localparam logic signed [15:0] ENV_MIN  = 16'sh8000;
  localparam logic signed [15:0] ENV_MAX  = 16'sh7FFF;

  // Magnitude thresholds beyond which a result saturates.
  localparam logic [31:0] MEAN_POS_LIM = 32'd524287;
  localparam logic [31:0] MEAN_NEG_LIM = 32'd524288;
  localparam logic [31:0] ENV_POS_LIM  = 32'd32767;
  localparam logic [31:0] ENV_NEG_LIM  = 32'd32768;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic signed [19:0] mean_x;
    logic signed [19:0] mean_y;
    logic signed [19:0] mean_z;
    logic signed [15:0] lowest_x;
    logic signed [15:0] lowest_y;
    logic signed [15:0] lowest_z;
    logic signed [15:0] highest_x;
    logic signed [15:0] highest_y;
    logic signed [15:0] highest_z;
  } out_item_t;

  // Stage load enables handed to the divider lanes.
  typedef struct packed {
    logic load_prod;
    logic load_quot;
  } div_ctl_t;

endpackage

`default_nettype wire

/* rtl/tmae_ring.sv */
// Sample ring memory: one read-first access per transfer, with a fill flag.
`timescale 1ns / 1ps
`default_nettype none

module tmae_ring #(
  parameter int WINDOW = 10,
  parameter int SW     = 16
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic [3*SW-1:0]   wdata,
  output logic      [3*SW-1:0]   old
);

  localparam int PW = $clog2(WINDOW);

  logic [3*SW-1:0] mem [WINDOW];
  logic [3*SW-1:0] rdata;
  logic [PW-1:0]   ptr;
  logic            filled;
  logic            live;

  // Read the retiring entry and overwrite it in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      rdata    <= mem[ptr];
      mem[ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ptr    <= '0;
      filled <= 1'b0;
      live   <= 1'b0;
    end else if (accept) begin
      live <= filled;
      if (ptr == PW'(WINDOW - 1)) begin
        ptr    <= '0;
        filled <= 1'b1;
      end else begin
        ptr <= ptr + 1'b1;
      end
    end
  end

  // Entries not yet written since reset read as zero.
  assign old = live ? rdata : '0;

endmodule

`default_nettype wire

/* rtl/tmae_recip_div.sv */
// Two-stage divider by the window length: reciprocal multiply, then one correction.
`timescale 1ns / 1ps
`default_nettype none

module tmae_recip_div #(
  parameter int WINDOW = 10,
  parameter int NB     = 24
) (
  input  wire logic               clk,
  input  wire tmae_pkg::div_ctl_t ctl,
  input  wire logic [NB-1:0]      mag,
  input  wire logic               neg,
  output logic      [NB-1:0]      quot,
  output logic                    quot_neg
);

  localparam int PW = 2 * NB;
  localparam logic [NB-1:0] RECIP   = NB'((64'd1 << NB) / WINDOW);
  localparam logic [NB-1:0] DIVISOR = NB'(WINDOW);

  logic [PW-1:0] prod;
  logic [NB-1:0] mag_d;
  logic          neg_d;
  logic [NB-1:0] q0;
  logic [NB-1:0] rem;
  logic [NB-1:0] q_fix;

  always_ff @(posedge clk) begin
    if (ctl.load_prod) begin
      prod  <= PW'(mag) * PW'(RECIP);
      mag_d <= mag;
      neg_d <= neg;
    end
  end

  // The estimate is low by at most one; bump it when the remainder allows.
  always_comb begin
    q0    = prod[PW-1:NB];
    rem   = mag_d - NB'(q0 * DIVISOR);
    q_fix = (rem >= DIVISOR) ? q0 + NB'(1) : q0;
  end

  always_ff @(posedge clk) begin
    if (ctl.load_quot) begin
      quot     <= q_fix;
      quot_neg <= neg_d;
    end
  end

endmodule

`default_nettype wire

/* rtl/triaxial_moving_average_envelope.sv */
// Top level of the three-axis boxcar moving average with a min/max envelope.
`timescale 1ns / 1ps
`default_nettype none

// Takes one three-axis sample per transfer and returns one result per sample:
// the mean of the last WINDOW samples of each axis in signed Q.4, truncated
// toward zero, plus the smallest and largest integer mean of each axis seen
// since reset. Both envelopes start at zero, and the sample ring counts as
// all zeros until WINDOW samples have gone in, so there is no clearing pass
// after reset. The block sustains one sample per clock while results are taken:
// the ring memory has one read-first access per transfer and the running sums
// take one update per cycle. A sample passes the input, sum, product, quotient
// and output registers in turn; back-pressure on the result side fills the five
// stages before sample_ready drops. Samples narrower than 16 bits are taken from
// the low SAMPLE_BITS bits and sign-extended; above 16 bits the field is zero-extended.
module triaxial_moving_average_envelope #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_valid,
  output logic                     sample_ready,
  input  wire tmae_pkg::in_item_t  sample,
  output logic                     result_valid,
  input  wire logic                result_ready,
  output tmae_pkg::out_item_t      result
);

  import tmae_pkg::*;

  localparam int SW   = (SAMPLE_BITS > 16) ? 17 : SAMPLE_BITS;
  localparam int SEL  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
  localparam int SUMW = SW + $clog2(WINDOW);
  localparam int NB   = SUMW + 4;

  function automatic logic signed [SW-1:0] widen(input logic [15:0] raw);
    logic [SW-1:0] v;
    if (SAMPLE_BITS > 16) begin
      v = SW'(raw);
    end else begin
      v = SW'(signed'(raw[SEL-1:0]));
    end
    return signed'(v);
  endfunction

  // Stage enables: a stage loads when it is empty or its successor moves.
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4, en5;
  logic accept;
  div_ctl_t div_ctl;

  assign en5          = !result_valid || result_ready;
  assign en4          = !v4 || en5;
  assign en3          = !v3 || en4;
  assign en2          = !v2 || en3;
  assign en1          = !v1 || en2;
  assign sample_ready = en1;
  assign accept       = sample_valid && en1;

  assign div_ctl.load_prod = en3;
  assign div_ctl.load_quot = en4;

  logic [15:0]             raw [AXES];
  logic signed [SW-1:0]    s_in [AXES];
  logic signed [SW-1:0]    s1 [AXES];
  logic signed [SW-1:0]    old [AXES];
  logic [3*SW-1:0]         ring_wdata;
  logic [3*SW-1:0]         ring_old;

  assign raw[0] = sample.sample_x;
  assign raw[1] = sample.sample_y;
  assign raw[2] = sample.sample_z;

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      s_in[a]                 = widen(raw[a]);
      ring_wdata[a*SW +: SW]  = s_in[a];
      old[a]                  = signed'(ring_old[a*SW +: SW]);
    end
  end

  tmae_ring #(
    .WINDOW (WINDOW),
    .SW     (SW)
  ) u_ring (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .wdata  (ring_wdata),
    .old    (ring_old)
  );

  // Running sums: add the new sample, drop the one leaving the window.
  logic signed [SUMW-1:0] sum [AXES];
  logic signed [SUMW-1:0] sum_next [AXES];
  logic [SUMW-1:0]        sum_abs [AXES];
  logic [NB-1:0]          mag2 [AXES];
  logic                   neg2 [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sum_next[a] = SUMW'(sum[a] + s1[a] - old[a]);
      sum_abs[a]  = sum_next[a][SUMW-1] ? SUMW'(~sum_next[a] + 1'b1) : sum_next[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      for (int a = 0; a < AXES; a++) begin
        s1[a] <= s_in[a];
      end
    end
    if (en2) begin
      for (int a = 0; a < AXES; a++) begin
        mag2[a] <= {sum_abs[a], 4'b0000};
        neg2[a] <= sum_next[a][SUMW-1];
      end
    end
  end

  logic [NB-1:0] quot [AXES];
  logic          quot_neg [AXES];

  for (genvar a = 0; a < AXES; a++) begin : g_div
    tmae_recip_div #(
      .WINDOW (WINDOW),
      .NB     (NB)
    ) u_div (
      .clk      (clk),
      .ctl      (div_ctl),
      .mag      (mag2[a]),
      .neg      (neg2[a]),
      .quot     (quot[a]),
      .quot_neg (quot_neg[a])
    );
  end

  // Sign, saturate and fold into the envelopes.
  logic [31:0]              q_w [AXES];
  logic [31:0]              neg_q [AXES];
  logic [31:0]              whole_w [AXES];
  logic [31:0]              neg_whole [AXES];
  logic signed [19:0]       mean_c [AXES];
  logic signed [15:0]       whole [AXES];
  logic signed [15:0]       env_low [AXES];
  logic signed [15:0]       env_high [AXES];
  logic signed [15:0]       low_next [AXES];
  logic signed [15:0]       high_next [AXES];

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      q_w[a]       = 32'(quot[a]);
      neg_q[a]     = -q_w[a];
      whole_w[a]   = q_w[a] >> 4;
      neg_whole[a] = -whole_w[a];
      if (quot_neg[a]) begin
        mean_c[a] = (q_w[a] > MEAN_NEG_LIM) ? MEAN_MIN : signed'(neg_q[a][19:0]);
        whole[a]  = (whole_w[a] > ENV_NEG_LIM) ? ENV_MIN : signed'(neg_whole[a][15:0]);
      end else begin
        mean_c[a] = (q_w[a] > MEAN_POS_LIM) ? MEAN_MAX : signed'(q_w[a][19:0]);
        whole[a]  = (whole_w[a] > ENV_POS_LIM) ? ENV_MAX : signed'(whole_w[a][15:0]);
      end
      low_next[a]  = (whole[a] < env_low[a]) ? whole[a] : env_low[a];
      high_next[a] = (whole[a] > env_high[a]) ? whole[a] : env_high[a];
    end
  end

  // Control state: stage valids, running sums and envelopes.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        sum[a]      <= '0;
        env_low[a]  <= '0;
        env_high[a] <= '0;
      end
    end else begin
      if (en1) begin
        v1 <= accept;
      end
      if (en2) begin
        v2 <= v1;
        if (v1) begin
          for (int a = 0; a < AXES; a++) begin
            sum[a] <= sum_next[a];
          end
        end
      end
      if (en3) begin
        v3 <= v2;
      end
      if (en4) begin
        v4 <= v3;
      end
      if (en5) begin
        result_valid <= v4;
        if (v4) begin
          for (int a = 0; a < AXES; a++) begin
            env_low[a]  <= low_next[a];
            env_high[a] <= high_next[a];
          end
        end
      end
    end
  end

  // Output register: hold while the result waits for its transfer.
  always_ff @(posedge clk) begin
    if (en5 && v4) begin
      result.mean_x    <= mean_c[0];
      result.mean_y    <= mean_c[1];
      result.mean_z    <= mean_c[2];
      result.lowest_x  <= low_next[0];
      result.lowest_y  <= low_next[1];
      result.lowest_z  <= low_next[2];
      result.highest_x <= high_next[0];
      result.highest_y <= high_next[1];
      result.highest_z <= high_next[2];
    end
  end

  // Envelopes start at zero, so they bracket zero for good.
  a_env_brackets_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.lowest_x <= 16'sd0 && result.highest_x >= 16'sd0 &&
                      result.lowest_y <= 16'sd0 && result.highest_y >= 16'sd0 &&
                      result.lowest_z <= 16'sd0 && result.highest_z >= 16'sd0))
    else $error("envelope crossed zero");

  // The integer mean of this item on the x and z axes lies inside the envelope it produced.
  a_mean_in_env: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.lowest_x <= (result.mean_x / 20'sd16) &&
                      result.highest_x >= (result.mean_x / 20'sd16) &&
                      result.lowest_z <= (result.mean_z / 20'sd16) &&
                      result.highest_z >= (result.mean_z / 20'sd16)))
    else $error("integer mean outside its envelope");

endmodule

`default_nettype wire

/* sim/triaxial_moving_average_envelope_tb.sv */
// Testbench of the three-axis moving average envelope block, self-checking.
`timescale 1ns / 1ps

module triaxial_moving_average_envelope_tb;
  import tmae_pkg::*;

  localparam int WINDOW      = 10;
  localparam int RANDOM_ITEMS = 800;
  localparam int QUIET_FROM  = 700;      // random items from here on run with no idling
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE      = 20;

  typedef struct {
    in_item_t item;
    bit       drain;                      // hold until every result is back
    bit       quiet;
  } pending_sample_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        sample_valid = 1'b0;
  logic        sample_ready;
  in_item_t    sample = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  out_item_t   result;

  pending_sample_t pending[$];
  out_item_t       expected_results[$];
  int              error_count = 0;
  int              cycle_count = 0;

  // Predictor state: ring of the last WINDOW samples, running sums, envelopes.
  int ring[AXES][WINDOW];
  int ring_pos = 0;
  int axis_sum[AXES];
  int env_lo[AXES];
  int env_hi[AXES];

  triaxial_moving_average_envelope #(
    .WINDOW(WINDOW),
    .SAMPLE_BITS(16)
  ) dut (
    .clk(clk),
    .rst(rst),
    .sample_valid(sample_valid),
    .sample_ready(sample_ready),
    .sample(sample),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic int clamp_int(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Advance the ring by one sample and return the mean and envelope of each axis.
  function automatic out_item_t average_and_envelope(in_item_t s);
    int        raw[AXES];
    int        q4[AXES];
    int        whole;
    out_item_t r;
    raw[0] = int'(s.sample_x);
    raw[1] = int'(s.sample_y);
    raw[2] = int'(s.sample_z);
    for (int a = 0; a < AXES; a++) begin
      axis_sum[a] += raw[a] - ring[a][ring_pos];
      ring[a][ring_pos] = raw[a];
      q4[a] = clamp_int((axis_sum[a] * 16) / WINDOW, int'(MEAN_MIN), int'(MEAN_MAX));
      whole = clamp_int(axis_sum[a] / WINDOW, int'(ENV_MIN), int'(ENV_MAX));
      if (whole < env_lo[a]) env_lo[a] = whole;
      if (whole > env_hi[a]) env_hi[a] = whole;
    end
    ring_pos = (ring_pos + 1) % WINDOW;
    r.mean_x    = q4[0][19:0];
    r.mean_y    = q4[1][19:0];
    r.mean_z    = q4[2][19:0];
    r.lowest_x  = env_lo[0][15:0];
    r.lowest_y  = env_lo[1][15:0];
    r.lowest_z  = env_lo[2][15:0];
    r.highest_x = env_hi[0][15:0];
    r.highest_y = env_hi[1][15:0];
    r.highest_z = env_hi[2][15:0];
    return r;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    if (error_count <= 60) $display("%0t ns: %s", $time, what);
  endtask

  task automatic check_field(string name, int got, int want);
    if (got != want)
      report_mismatch($sformatf("%s: got %0d, expected %0d", name, got, want));
  endtask

  task automatic push_sample(int x, int y, int z, bit drain, bit quiet);
    pending_sample_t p;
    p.item.sample_x = x[15:0];
    p.item.sample_y = y[15:0];
    p.item.sample_z = z[15:0];
    p.drain = drain;
    p.quiet = quiet;
    pending.push_back(p);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return 32767;
      1: return -32768;
      2: return -1;
      3: return 1;
      default: return 0;
    endcase
  endfunction

  // Driver: present the next pending sample when the input slot frees up, unless a random gap or a drain holds it back.
  int gap_left = 0;
  int in_flight = 0;

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
      gap_left = 0;
      in_flight = 0;
    end else begin
      in_flight = in_flight + int'(sample_valid && sample_ready)
                            - int'(result_valid && result_ready);
      if (!sample_valid || sample_ready) begin
        if (gap_left != 0) begin
          gap_left--;
          sample_valid <= 1'b0;
        end else if (pending.size() == 0 || (pending[0].drain && in_flight != 0)) begin
          sample_valid <= 1'b0;
        end else if (!pending[0].quiet && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 18);
          sample_valid <= 1'b0;
        end else begin
          sample <= pending[0].item;
          pending.pop_front();
          sample_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: predict on each sample transfer, check each result transfer, and stall result_ready at random.
  int stall_left = 0;
  int calm_left = 0;
  int samples_taken = 0;
  out_item_t want;

  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with no sample outstanding");
        end else begin
          want = expected_results.pop_front();
          check_field("mean_x", result.mean_x, want.mean_x);
          check_field("mean_y", result.mean_y, want.mean_y);
          check_field("mean_z", result.mean_z, want.mean_z);
          check_field("lowest_x", result.lowest_x, want.lowest_x);
          check_field("lowest_y", result.lowest_y, want.lowest_y);
          check_field("lowest_z", result.lowest_z, want.lowest_z);
          check_field("highest_x", result.highest_x, want.highest_x);
          check_field("highest_y", result.highest_y, want.highest_y);
          check_field("highest_z", result.highest_z, want.highest_z);
        end
      end
      if (sample_valid && sample_ready) begin
        expected_results.push_back(average_and_envelope(sample));
        samples_taken++;
      end
      if (stall_left != 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (calm_left != 0) begin
        calm_left--;
        result_ready <= 1'b1;
      end else if (samples_taken < 25 + QUIET_FROM && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(20, 60);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("triaxial_moving_average_envelope_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int n;
    int len;
    int cx, cy, cz;

    for (int a = 0; a < AXES; a++) begin
      axis_sum[a] = 0;
      env_lo[a] = 0;
      env_hi[a] = 0;
      for (int i = 0; i < WINDOW; i++) ring[a][i] = 0;
    end

    // Directed: a zero sample leaves both envelopes at zero, then full windows
    // of opposite extremes drive the x and y envelopes to their limits.
    push_sample(0, 0, 0, 1'b0, 1'b0);
    for (int i = 0; i < WINDOW; i++) push_sample(32767, -32768, 1, 1'b0, 1'b0);
    for (int i = 0; i < WINDOW; i++) push_sample(-32768, 32767, -1, 1'b0, 1'b0);
    push_sample(-1, -1, -1, 1'b0, 1'b0);
    push_sample(-5, 7, -15, 1'b0, 1'b0);
    push_sample(1, 2, 3, 1'b0, 1'b0);

    // Random: mixes of full-range noise, steady runs that pull the mean onto a
    // value, small values that exercise truncation toward zero, and extremes.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      len = $urandom_range(8, 20);
      cx = $signed($urandom_range(0, 65535)) - 32768;
      cy = $signed($urandom_range(0, 65535)) - 32768;
      cz = $signed($urandom_range(0, 65535)) - 32768;
      case ($urandom_range(0, 3))
        0: for (int i = 0; i < len; i++) begin
          push_sample($urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 65535), n == 0 || n == 400, n >= QUIET_FROM);
          n++;
        end
        1: for (int i = 0; i < len; i++) begin
          push_sample(cx, cy, cz, n == 0 || n == 400, n >= QUIET_FROM);
          n++;
        end
        2: for (int i = 0; i < len; i++) begin
          push_sample(int'($urandom_range(0, 64)) - 32, int'($urandom_range(0, 64)) - 32,
                      int'($urandom_range(0, 64)) - 32, n == 0 || n == 400,
                      n >= QUIET_FROM);
          n++;
        end
        default: for (int i = 0; i < len; i++) begin
          push_sample(pick_extreme(), pick_extreme(), pick_extreme(), n == 0 || n == 400,
                      n >= QUIET_FROM);
          n++;
        end
      endcase
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    do @(negedge clk);
    while (pending.size() != 0 || sample_valid || expected_results.size() != 0);
    repeat (SETTLE) @(posedge clk);

    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("triaxial_moving_average_envelope_tb: done, clean");
    end else begin
      $display("triaxial_moving_average_envelope_tb: done, errors");
    end
    $finish;
  end

endmodule

/* triaxial_moving_average_envelope.f */
rtl/tmae_pkg.sv
rtl/tmae_ring.sv
rtl/tmae_recip_div.sv
rtl/triaxial_moving_average_envelope.sv
sim/triaxial_moving_average_envelope_tb.sv
